### hw/rtl/sdspi_pkg.sv
// Package for the SD card SPI host: operation, config index and status codes,
// card kinds and shared word types. No dependencies.
package sdspi_pkg;

  localparam int unsigned BlockBytes    = 512;
  localparam int unsigned ResponsePolls = 10;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    OpInit = 2'd0, OpRead = 2'd1, OpByte = 2'd2, OpTick = 2'd3
  } op_e;

  localparam logic [1:0] CfgInitTimeout  = 2'd0;
  localparam logic [1:0] CfgReadyTimeout = 2'd1;
  localparam logic [1:0] CfgTokenTimeout = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatParam   = 2'd1;
  localparam logic [1:0] StatNotRdy  = 2'd2;
  localparam logic [1:0] StatError   = 2'd3;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindMmc    = 3'd1;
  localparam logic [2:0] KindSd1    = 3'd2;
  localparam logic [2:0] KindSd2    = 3'd3;
  localparam logic [2:0] KindSd2Blk = 3'd4;

  // Word handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  miso;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       cs_active;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done;
    logic [1:0] status;
    logic [2:0] card_type;
    logic       not_ready;
    logic       fast_clock;
  } result_t;

endpackage

### hw/rtl/sd_card_spi_host.sv
// SD card SPI host top: input queue (front), protocol engine (back), result queue.
// The engine forms each result word combinationally and pushes it into the result queue.
// Throughput: one word per cycle while the result queue is not full.
// Reset: asynchronous, active low; queues empty, registers at defaults, no card.
// Depends on sdspi_pkg, sdspi_fifo, sdspi_engine.
module sd_card_spi_host #(
  parameter int unsigned ResponsePolls = sdspi_pkg::ResponsePolls
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] sector_i,
  input  logic [15:0] count_i,
  input  logic [7:0]  miso_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  mosi_byte_o,
  output logic        mosi_valid_o,
  output logic        cs_active_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        data_last_o,
  output logic        request_done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  card_type_o,
  output logic        not_ready_o,
  output logic        fast_clock_o
);
  import sdspi_pkg::*;

  item_t   in_w, q_w;
  result_t res_w, out_w;
  logic q_empty, take, res_full, res_push;

  assign in_w = '{op: operation_i, sector: sector_i, count: count_i, miso: miso_byte_i};

  // front queue
  sdspi_fifo #(.word_t(item_t), .Depth(QueueDepth)) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(in_w), .full_o(full),
    .pop_i(take), .rdata_o(q_w), .empty_o(q_empty)
  );

  // protocol engine
  sdspi_engine #(.ResponsePolls(ResponsePolls)) u_engine (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(!q_empty), .in_item_i(q_w), .in_take_o(take),
    .out_full_i(res_full), .out_push_o(res_push), .out_res_o(res_w)
  );

  // result queue
  sdspi_fifo #(.word_t(result_t), .Depth(QueueDepth)) u_out_q (
    .clk_i, .rst_ni, .push_i(res_push), .wdata_i(res_w), .full_o(res_full),
    .pop_i(pop), .rdata_o(out_w), .empty_o(empty)
  );

  assign mosi_byte_o          = out_w.mosi_byte;
  assign mosi_valid_o         = out_w.mosi_valid;
  assign cs_active_o          = out_w.cs_active;
  assign data_byte_o          = out_w.data_byte;
  assign data_valid_o         = out_w.data_valid;
  assign data_last_o          = out_w.data_last;
  assign request_done_o       = out_w.done;
  assign status_o             = out_w.status;
  assign card_type_o          = out_w.card_type;
  assign not_ready_o          = out_w.not_ready;
  assign fast_clock_o         = out_w.fast_clock;

  // idle byte is all ones whenever no exchange starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !mosi_valid_o) |-> (mosi_byte_o == 8'hFF))
    else $error("mosi byte not idle");
  // status only reported with done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !request_done_o) |-> (status_o == StatOk))
    else $error("status without done");
  // last flag only with data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_last_o) |-> data_valid_o)
    else $error("last without data");
endmodule

### hw/rtl/sdspi_fifo.sv
// Small register queue with push/pop and full/empty flags.
// Depends on nothing; the word type is a parameter.
module sdspi_fifo #(
  parameter type word_t = logic [7:0],
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output word_t rdata_o,
  output logic  empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  word_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end
endmodule

### hw/rtl/sdspi_engine.sv
// Back end: the SD SPI protocol state machine, one word per cycle unless out_full_i.
// Depends on sdspi_pkg.
module sdspi_engine #(
  parameter int unsigned ResponsePolls = sdspi_pkg::ResponsePolls
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  input  sdspi_pkg::item_t in_item_i,
  output logic             in_take_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output sdspi_pkg::result_t out_res_o
);
  import sdspi_pkg::*;

  typedef enum logic [3:0] {
    PIdle, PClocks, PR7, POcr, PInitEnd, PDesel, PSelDummy, PReady,
    PFrame, PSkip, PPoll, PFailDesel, PToken, PData, PCrc, PReadEnd
  } phase_e;

  typedef enum logic [3:0] {
    KNone, KCmd0, KCmd8, KV2Loop, KCmd58, KV1Probe, KV1Loop, KCmd16, KReadCmd, KStop
  } kont_e;

  localparam int unsigned PW = $clog2(ResponsePolls + 1);

  logic [15:0] init_to_q, ready_to_q, token_to_q;
  phase_e phase_q, phase_d;
  kont_e  kont_q, kont_d;
  logic [2:0]  kind_q, kind_d, trial_q, trial_d;
  logic        uninit_q, uninit_d, cs_q, cs_d, fast_q, fast_d, app_q, app_d;
  logic [5:0]  cidx_q, cidx_d;
  logic [31:0] carg_q, carg_d, ocr_q, ocr_d;
  logic [9:0]  bcnt_q, bcnt_d;
  logic [PW-1:0] poll_q, poll_d;
  logic [15:0] left_q, left_d, itmr_q, itmr_d, wtmr_q, wtmr_d;
  result_t r;

  logic [5:0]  cur_idx;
  logic [31:0] cur_arg;
  logic [7:0]  b;
  logic [31:0] ocr_next;
  logic        ok_blk;
  logic [15:0] left_dec;
  logic [7:0]  res;
  logic        do_resume;
  logic        poll_zero;

  assign in_take_o  = in_valid_i && !out_full_i;
  assign out_push_o = in_take_o;
  assign cur_idx    = app_q ? 6'd55 : cidx_q;
  assign cur_arg    = app_q ? 32'd0 : carg_q;
  assign b          = in_item_i.miso;
  assign ocr_next   = {ocr_q[23:0], b};

  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] v;
    unique case (k)
      3'd0: v = 8'h40 | {2'b00, idx};
      3'd1: v = arg[31:24];
      3'd2: v = arg[23:16];
      3'd3: v = arg[15:8];
      3'd4: v = arg[7:0];
      default: v = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return v;
  endfunction

  // next-state logic, mirrors the event semantics
  always_comb begin
    phase_d = phase_q; kont_d = kont_q; kind_d = kind_q; trial_d = trial_q;
    uninit_d = uninit_q; cs_d = cs_q; fast_d = fast_q; app_d = app_q;
    cidx_d = cidx_q; carg_d = carg_q; ocr_d = ocr_q; bcnt_d = bcnt_q;
    poll_d = poll_q; left_d = left_q; itmr_d = itmr_q; wtmr_d = wtmr_q;
    r = '0; r.mosi_byte = 8'hFF;
    ok_blk = 1'b0; left_dec = left_q; res = 8'h00; do_resume = 1'b0;
    poll_zero = 1'b0;

    // Pass 1: event dispatch, may request a resume with response res.
    // Command issue and block end are written inline via small flags below.
    unique case (op_e'(in_item_i.op))
      OpTick: begin
        if (itmr_q != '0) itmr_d = itmr_q - 1'b1;
        if (wtmr_q != '0) wtmr_d = wtmr_q - 1'b1;
      end
      OpInit, OpRead: begin
        if (phase_q == PIdle) begin
          if (in_item_i.op == OpInit) begin
            fast_d = 1'b0; bcnt_d = '0; cs_d = 1'b0;
            r.mosi_valid = 1'b1; phase_d = PClocks;
          end else if (in_item_i.count == '0) begin
            r.done = 1'b1; r.status = StatParam;
          end else if (uninit_q) begin
            r.done = 1'b1; r.status = StatNotRdy;
          end else begin
            left_d = in_item_i.count;
            cidx_d = (in_item_i.count == 16'd1) ? 6'd17 : 6'd18;
            carg_d = (kind_q != KindSd2Blk) ? {in_item_i.sector[22:0], 9'd0}
                                            : in_item_i.sector;
            app_d = 1'b0; kont_d = KReadCmd;
            cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PDesel;
          end
        end
      end
      default: begin
        unique case (phase_q)
          PIdle: ;
          PClocks: begin
            bcnt_d = bcnt_q + 1'b1;
            if (bcnt_d < 10'd11) r.mosi_valid = 1'b1;
            else begin
              cidx_d = 6'd0; carg_d = '0; app_d = 1'b0; kont_d = KCmd0;
              cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PDesel;
            end
          end
          PR7, POcr: begin
            ocr_d = ocr_next;
            bcnt_d = bcnt_q + 1'b1;
            if (bcnt_d < 10'd4) r.mosi_valid = 1'b1;
            else if (phase_q == PR7) begin
              if (ocr_next[15:0] == 16'h01AA) begin
                if (itmr_q != '0) begin
                  cidx_d = 6'd41; carg_d = 32'h4000_0000; app_d = 1'b1; kont_d = KV2Loop;
                  cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PDesel;
                end else begin
                  kind_d = KindNone; cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PInitEnd;
                end
              end else begin
                kind_d = KindNone; cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PInitEnd;
              end
            end else begin
              kind_d = ocr_next[30] ? KindSd2Blk : KindSd2;
              cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PInitEnd;
            end
          end
          PInitEnd: begin
            if (kind_q != KindNone) begin
              fast_d = 1'b1; uninit_d = 1'b0; r.status = StatOk;
            end else begin
              uninit_d = 1'b1; r.status = StatError;
            end
            r.done = 1'b1; phase_d = PIdle;
          end
          PDesel: begin
            cs_d = 1'b1; r.mosi_valid = 1'b1; phase_d = PSelDummy;
          end
          PSelDummy: begin
            wtmr_d = ready_to_q; r.mosi_valid = 1'b1; phase_d = PReady;
          end
          PReady: begin
            if (b == 8'hFF) begin
              r.mosi_byte = frame_byte(3'd0, cur_idx, cur_arg); r.mosi_valid = 1'b1;
              bcnt_d = 10'd1; phase_d = PFrame;
            end else if (wtmr_q == '0) begin
              cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PFailDesel;
            end else r.mosi_valid = 1'b1;
          end
          PFailDesel: begin
            res = 8'hFF; do_resume = 1'b1;
          end
          PFrame: begin
            r.mosi_valid = 1'b1;
            if (bcnt_q < 10'd6) begin
              r.mosi_byte = frame_byte(bcnt_q[2:0], cur_idx, cur_arg);
              bcnt_d = bcnt_q + 1'b1;
            end else if (cur_idx == 6'd12) phase_d = PSkip;
            else begin
              poll_d = PW'(ResponsePolls); phase_d = PPoll;
            end
          end
          PSkip: begin
            r.mosi_valid = 1'b1; poll_d = PW'(ResponsePolls); phase_d = PPoll;
          end
          PPoll: begin
            if (poll_q != '0) poll_d = poll_q - 1'b1;
            poll_zero = (poll_d == '0);
            if (b[7] && !poll_zero) r.mosi_valid = 1'b1;
            else begin
              res = b; do_resume = 1'b1;
            end
          end
          PToken: begin
            if (b == 8'hFF && wtmr_q != '0) r.mosi_valid = 1'b1;
            else if (b != 8'hFE) ok_blk = 1'b0;
            else begin
              bcnt_d = '0; r.mosi_valid = 1'b1; phase_d = PData;
            end
          end
          PData: begin
            r.data_byte = b; r.data_valid = 1'b1;
            bcnt_d = bcnt_q + 1'b1;
            if (bcnt_q == 10'(BlockBytes - 1)) begin
              r.data_last = 1'b1; bcnt_d = '0; phase_d = PCrc;
            end
            r.mosi_valid = 1'b1;
          end
          PCrc: begin
            bcnt_d = bcnt_q + 1'b1;
            if (bcnt_d < 10'd2) r.mosi_valid = 1'b1;
            else ok_blk = 1'b1;
          end
          PReadEnd: begin
            r.done = 1'b1;
            r.status = (left_q != '0) ? StatError : StatOk;
            phase_d = PIdle;
          end
          default: ;
        endcase
      end
    endcase

    // block end: after CRC, or a token failure
    if (in_item_i.op == OpByte &&
        ((phase_q == PCrc && ok_blk) ||
         (phase_q == PToken && !(b == 8'hFF && wtmr_q != '0) && b != 8'hFE))) begin
      left_dec = (ok_blk && left_q != '0) ? left_q - 1'b1 : left_q;
      left_d = left_dec;
      r.mosi_valid = 1'b1;
      if (cidx_q == 6'd17) begin
        cs_d = 1'b0; phase_d = PReadEnd;
      end else if (ok_blk && left_dec != '0) begin
        wtmr_d = token_to_q; phase_d = PToken;
      end else begin
        // CMD12 goes out without the busy wait
        cidx_d = 6'd12; carg_d = '0; app_d = 1'b0; kont_d = KStop;
        r.mosi_byte = 8'h4C; bcnt_d = 10'd1; phase_d = PFrame;
      end
    end

    // command completion
    if (do_resume) begin
      if (app_q && res <= 8'd1) begin
        app_d = 1'b0;
        // next command in the pair is never CMD12
        cs_d = 1'b0; r.mosi_valid = 1'b1; phase_d = PDesel;
      end else begin
        app_d = 1'b0;
        r.mosi_valid = 1'b1;
        cs_d = 1'b0; phase_d = PInitEnd; kind_d = KindNone;  // finish_init(0) default
        unique case (kont_q)
          KCmd0: if (res == 8'd1) begin
            itmr_d = init_to_q; kind_d = kind_q;
            cidx_d = 6'd8; carg_d = 32'h1AA; kont_d = KCmd8; phase_d = PDesel;
          end
          KCmd8: begin
            kind_d = kind_q;
            if (res == 8'd1) begin
              ocr_d = '0; bcnt_d = '0; cs_d = cs_q; phase_d = PR7;
            end else begin
              cidx_d = 6'd41; carg_d = '0; app_d = 1'b1; kont_d = KV1Probe;
              phase_d = PDesel;
            end
          end
          KV2Loop: if (itmr_q != '0) begin
            kind_d = kind_q; phase_d = PDesel;
            if (res != 8'd0) begin
              cidx_d = 6'd41; carg_d = 32'h4000_0000; app_d = 1'b1;
            end else begin
              cidx_d = 6'd58; carg_d = '0; kont_d = KCmd58;
            end
          end
          KCmd58: if (res == 8'd0) begin
            kind_d = kind_q; ocr_d = '0; bcnt_d = '0; cs_d = cs_q; phase_d = POcr;
          end
          KV1Probe, KV1Loop: begin
            if (kont_q == KV1Probe) trial_d = (res <= 8'd1) ? KindSd1 : KindMmc;
            if (itmr_q != '0 && (kont_q == KV1Probe || res != 8'd0)) begin
              kind_d = kind_q; phase_d = PDesel; kont_d = KV1Loop; carg_d = '0;
              if (((kont_q == KV1Probe) ? ((res <= 8'd1) ? KindSd1 : KindMmc)
                                        : trial_q) == KindSd1) begin
                cidx_d = 6'd41; app_d = 1'b1;
              end else cidx_d = 6'd1;
            end else if (itmr_q != '0) begin
              kind_d = kind_q; phase_d = PDesel;
              cidx_d = 6'd16; carg_d = 32'd512; kont_d = KCmd16;
            end
          end
          KCmd16: kind_d = (res == 8'd0) ? trial_q : KindNone;
          KReadCmd: begin
            kind_d = kind_q;
            if (res == 8'd0) begin
              wtmr_d = token_to_q; cs_d = cs_q; phase_d = PToken;
            end else phase_d = PReadEnd;
          end
          default: begin
            kind_d = kind_q; phase_d = PReadEnd;
          end
        endcase
      end
    end

    r.cs_active  = cs_d;
    r.card_type  = kind_d;
    r.not_ready  = uninit_d;
    r.fast_clock = fast_d;
  end

  assign out_res_o = r;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_to_q <= 16'd1000; ready_to_q <= 16'd500; token_to_q <= 16'd200;
      phase_q <= PIdle; kont_q <= KNone; kind_q <= KindNone; trial_q <= KindNone;
      uninit_q <= 1'b1; cs_q <= 1'b0; fast_q <= 1'b0; app_q <= 1'b0;
      cidx_q <= '0; carg_q <= '0; ocr_q <= '0; bcnt_q <= '0; poll_q <= '0;
      left_q <= '0; itmr_q <= '0; wtmr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgInitTimeout:  init_to_q  <= cfg_data_i;
          CfgReadyTimeout: ready_to_q <= cfg_data_i;
          CfgTokenTimeout: token_to_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_take_o) begin
        phase_q <= phase_d; kont_q <= kont_d; kind_q <= kind_d; trial_q <= trial_d;
        uninit_q <= uninit_d; cs_q <= cs_d; fast_q <= fast_d; app_q <= app_d;
        cidx_q <= cidx_d; carg_q <= carg_d; ocr_q <= ocr_d; bcnt_q <= bcnt_d;
        poll_q <= poll_d; left_q <= left_d; itmr_q <= itmr_d; wtmr_q <= wtmr_d;
      end
    end
  end
endmodule

### tb/sv/testbench.sv
// Testbench for sd_card_spi_host: an emulated card drives request, byte and tick words
// through the input queue, and a predictor checks every result word. Depends on sdspi_pkg.
module testbench;
  import sdspi_pkg::*;

  typedef enum logic [5:0] {
    PhIdle, PhClocks, PhR7, PhOcr, PhInitEnd, PhDesel, PhSelDummy, PhReady,
    PhFrame, PhSkip, PhPoll, PhFailDesel, PhToken, PhData, PhCrc, PhReadEnd
  } phase_e;

  typedef enum logic [3:0] {
    RsNone, RsGoIdle, RsIfCond, RsV2Loop, RsReadOcr, RsV1Probe, RsV1Loop,
    RsBlkLen, RsReadCmd, RsStop
  } resume_e;

  // SD command indexes
  localparam logic [5:0] CmdGoIdle     = 6'd0;
  localparam logic [5:0] CmdSendOp     = 6'd1;
  localparam logic [5:0] CmdIfCond     = 6'd8;
  localparam logic [5:0] CmdStop       = 6'd12;
  localparam logic [5:0] CmdBlkLen     = 6'd16;
  localparam logic [5:0] CmdReadSingle = 6'd17;
  localparam logic [5:0] CmdReadMulti  = 6'd18;
  localparam logic [5:0] CmdAppOp      = 6'd41;
  localparam logic [5:0] CmdAppPrefix  = 6'd55;
  localparam logic [5:0] CmdReadOcr    = 6'd58;

  localparam logic [7:0] ByteIdle  = 8'hFF;
  localparam logic [7:0] ByteToken = 8'hFE;

  typedef struct {
    phase_e      phase;
    resume_e     resume;
    logic [2:0]  kind, trial;
    bit          uninit, app, cs, fast;
    logic [5:0]  cmd;
    logic [31:0] arg, ocr;
    logic [15:0] bc, left, itmr, wtmr;
    logic [3:0]  poll;
    logic [15:0] init_to, ready_to, token_to;
  } host_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgInitTimeout;
  logic [15:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = OpTick;
  logic [31:0] sector_i = '0;
  logic [15:0] count_i = '0;
  logic [7:0]  miso_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  mosi_byte_o, data_byte_o;
  logic        mosi_valid_o, cs_active_o, data_valid_o, data_last_o;
  logic        request_done_o, not_ready_o, fast_clock_o;
  logic [1:0]  status_o;
  logic [2:0]  card_type_o;

  sd_card_spi_host dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t       pending_words[$];
  result_t     expected_words[$];
  host_state_t model_st, gen_st;
  int          errors = 0;
  int          n_sent = 0;  // input words generated so far
  int          flavor = 0;  // emulated card: 0 SDv2, 1 SDv1, 2 MMC
  bit          clean = 0;   // no noise from the emulated card

  // ---------------- predictor ----------------
  function automatic host_state_t host_reset();
    host_state_t s;
    s.phase = PhIdle; s.resume = RsNone; s.kind = KindNone; s.trial = KindNone;
    s.uninit = 1; s.app = 0; s.cs = 0; s.fast = 0; s.cmd = CmdGoIdle;
    s.arg = '0; s.ocr = '0; s.bc = '0; s.left = '0; s.itmr = '0; s.wtmr = '0;
    s.poll = '0; s.init_to = 16'd1000; s.ready_to = 16'd500; s.token_to = 16'd200;
    return s;
  endfunction

  function automatic void emit(inout result_t r, input logic [7:0] b);
    r.mosi_byte = b;
    r.mosi_valid = 1'b1;
  endfunction

  function automatic void desel(inout host_state_t s, inout result_t r, input phase_e nx);
    s.cs = 0;
    emit(r, ByteIdle);
    s.phase = nx;
  endfunction

  function automatic logic [5:0] cur_cmd(host_state_t s);
    return s.app ? CmdAppPrefix : s.cmd;
  endfunction

  function automatic logic [7:0] frame_byte(host_state_t s, int k);
    logic [5:0]  idx;
    logic [31:0] a;
    idx = cur_cmd(s);
    a = s.app ? 32'd0 : s.arg;
    case (k)
      0: return 8'h40 | {2'b00, idx};
      1: return a[31:24];
      2: return a[23:16];
      3: return a[15:8];
      4: return a[7:0];
      default: return (idx == CmdGoIdle) ? 8'h95 : ((idx == CmdIfCond) ? 8'h87 : 8'h01);
    endcase
  endfunction

  function automatic void begin_cmd(inout host_state_t s, inout result_t r);
    if (cur_cmd(s) == CmdStop) begin
      emit(r, frame_byte(s, 0));
      s.bc = 1;
      s.phase = PhFrame;
    end else begin
      desel(s, r, PhDesel);
    end
  endfunction

  function automatic void issue(inout host_state_t s, inout result_t r, input logic [5:0] idx,
                                input bit app, input logic [31:0] a, input resume_e k);
    s.cmd = idx; s.arg = a; s.app = app; s.resume = k;
    begin_cmd(s, r);
  endfunction

  function automatic void finish_init(inout host_state_t s, inout result_t r,
                                      input logic [2:0] kind);
    s.kind = kind;
    desel(s, r, PhInitEnd);
  endfunction

  function automatic void start_token(inout host_state_t s, inout result_t r);
    s.wtmr = s.token_to;
    emit(r, ByteIdle);
    s.phase = PhToken;
  endfunction

  function automatic void v2_loop(inout host_state_t s, inout result_t r);
    if (s.itmr != 0) issue(s, r, CmdAppOp, 1, 32'h4000_0000, RsV2Loop);
    else finish_init(s, r, KindNone);
  endfunction

  function automatic void v1_loop(inout host_state_t s, inout result_t r);
    if (s.itmr == 0) finish_init(s, r, KindNone);
    else if (s.trial == KindSd1) issue(s, r, CmdAppOp, 1, 32'd0, RsV1Loop);
    else issue(s, r, CmdSendOp, 0, 32'd0, RsV1Loop);
  endfunction

  function automatic void block_end(inout host_state_t s, inout result_t r, input bit ok);
    if (ok && s.left != 0) s.left--;
    if (s.cmd == CmdReadSingle) desel(s, r, PhReadEnd);
    else if (ok && s.left != 0) start_token(s, r);
    else issue(s, r, CmdStop, 0, 32'd0, RsStop);
  endfunction

  // continue the running sequence with the response of the last command
  function automatic void resume_with(inout host_state_t s, inout result_t r,
                                      input logic [7:0] res);
    case (s.resume)
      RsGoIdle:
        if (res == 8'd1) begin
          s.itmr = s.init_to;
          issue(s, r, CmdIfCond, 0, 32'h1AA, RsIfCond);
        end else finish_init(s, r, KindNone);
      RsIfCond:
        if (res == 8'd1) begin
          s.ocr = 0; s.bc = 0; emit(r, ByteIdle); s.phase = PhR7;
        end else issue(s, r, CmdAppOp, 1, 32'd0, RsV1Probe);
      RsV2Loop:
        if (res != 0) v2_loop(s, r);
        else if (s.itmr != 0) issue(s, r, CmdReadOcr, 0, 32'd0, RsReadOcr);
        else finish_init(s, r, KindNone);
      RsReadOcr:
        if (res == 0) begin
          s.ocr = 0; s.bc = 0; emit(r, ByteIdle); s.phase = PhOcr;
        end else finish_init(s, r, KindNone);
      RsV1Probe: begin
        s.trial = (res <= 8'd1) ? KindSd1 : KindMmc;
        v1_loop(s, r);
      end
      RsV1Loop:
        if (res != 0) v1_loop(s, r);
        else if (s.itmr != 0) issue(s, r, CmdBlkLen, 0, 32'd512, RsBlkLen);
        else finish_init(s, r, KindNone);
      RsBlkLen: finish_init(s, r, (res == 0) ? s.trial : KindNone);
      RsReadCmd:
        if (res == 0) start_token(s, r);
        else desel(s, r, PhReadEnd);
      default: desel(s, r, PhReadEnd);
    endcase
  endfunction

  function automatic void command_done(inout host_state_t s, inout result_t r,
                                       input logic [7:0] res);
    if (s.app) begin
      s.app = 0;
      // a CMD55 error stands for the ACMD41 response
      if (res > 8'd1) resume_with(s, r, res);
      else begin_cmd(s, r);
    end else begin
      resume_with(s, r, res);
    end
  endfunction

  function automatic void byte_in(inout host_state_t s, inout result_t r, input logic [7:0] b);
    case (s.phase)
      PhClocks: begin
        s.bc++;
        if (s.bc < 11) emit(r, ByteIdle);
        else issue(s, r, CmdGoIdle, 0, 32'd0, RsGoIdle);
      end
      PhR7, PhOcr: begin
        s.ocr = {s.ocr[23:0], b};
        s.bc++;
        if (s.bc < 4) emit(r, ByteIdle);
        else if (s.phase == PhR7) begin
          if (s.ocr[15:0] == 16'h01AA) v2_loop(s, r);
          else finish_init(s, r, KindNone);
        end else begin
          finish_init(s, r, s.ocr[30] ? KindSd2Blk : KindSd2);
        end
      end
      PhInitEnd: begin
        if (s.kind != KindNone) begin
          s.fast = 1; s.uninit = 0; r.status = StatOk;
        end else begin
          s.uninit = 1; r.status = StatError;
        end
        r.done = 1;
        s.phase = PhIdle;
      end
      PhDesel: begin
        s.cs = 1; emit(r, ByteIdle); s.phase = PhSelDummy;
      end
      PhSelDummy: begin
        s.wtmr = s.ready_to; emit(r, ByteIdle); s.phase = PhReady;
      end
      PhReady:
        if (b == ByteIdle) begin
          emit(r, frame_byte(s, 0)); s.bc = 1; s.phase = PhFrame;
        end else if (s.wtmr == 0) desel(s, r, PhFailDesel);
        else emit(r, ByteIdle);
      PhFailDesel: command_done(s, r, ByteIdle);
      PhFrame:
        if (s.bc < 6) begin
          emit(r, frame_byte(s, s.bc)); s.bc++;
        end else if (cur_cmd(s) == CmdStop) begin
          emit(r, ByteIdle); s.phase = PhSkip;
        end else begin
          emit(r, ByteIdle); s.poll = 4'(ResponsePolls); s.phase = PhPoll;
        end
      PhSkip: begin
        emit(r, ByteIdle); s.poll = 4'(ResponsePolls); s.phase = PhPoll;
      end
      PhPoll: begin
        if (s.poll != 0) s.poll--;
        if (b[7] && s.poll != 0) emit(r, ByteIdle);
        else command_done(s, r, b);
      end
      PhToken:
        if (b == ByteIdle && s.wtmr != 0) emit(r, ByteIdle);
        else if (b != ByteToken) block_end(s, r, 0);
        else begin
          s.bc = 0; emit(r, ByteIdle); s.phase = PhData;
        end
      PhData: begin
        r.data_byte = b; r.data_valid = 1;
        s.bc++;
        if (s.bc >= BlockBytes) begin
          r.data_last = 1; s.bc = 0; s.phase = PhCrc;
        end
        emit(r, ByteIdle);
      end
      PhCrc: begin
        s.bc++;
        if (s.bc < 2) emit(r, ByteIdle);
        else block_end(s, r, 1);
      end
      PhReadEnd: begin
        r.done = 1;
        r.status = (s.left != 0) ? StatError : StatOk;
        s.phase = PhIdle;
      end
      default: ;
    endcase
  endfunction

  function automatic result_t host_step(inout host_state_t s, input item_t it);
    result_t     r;
    logic [31:0] sec;
    r = '0;
    r.mosi_byte = ByteIdle;
    if (it.op == OpTick) begin
      if (s.itmr != 0) s.itmr--;
      if (s.wtmr != 0) s.wtmr--;
    end else if (it.op == OpByte) begin
      if (s.phase != PhIdle) byte_in(s, r, it.miso);
    end else if (s.phase == PhIdle) begin
      if (it.op == OpInit) begin
        s.fast = 0; s.bc = 0;
        desel(s, r, PhClocks);
      end else if (it.count == 0) begin
        r.done = 1; r.status = StatParam;
      end else if (s.uninit) begin
        r.done = 1; r.status = StatNotRdy;
      end else begin
        sec = (s.kind != KindSd2Blk) ? (it.sector << 9) : it.sector;
        s.left = it.count;
        issue(s, r, (it.count == 1) ? CmdReadSingle : CmdReadMulti, 0, sec, RsReadCmd);
      end
    end
    r.cs_active = s.cs;
    r.card_type = s.kind;
    r.not_ready = s.uninit;
    r.fast_clock = s.fast;
    return r;
  endfunction

  // ---------------- emulated card ----------------
  function automatic logic [7:0] card_response(host_state_t s);
    case (cur_cmd(s))
      CmdGoIdle:    return (!clean && $urandom_range(0, 9) == 0) ? 8'h05 : 8'h01;
      CmdIfCond:    return (flavor == 0) ? 8'h01 : 8'h05;
      CmdAppPrefix: return (flavor == 2) ? 8'h05 : 8'h01;
      CmdAppOp, CmdSendOp: return ($urandom_range(0, 9) < 7) ? 8'h01 : 8'h00;
      CmdReadSingle, CmdReadMulti:
        return (!clean && $urandom_range(0, 19) == 0) ? 8'h04 : 8'h00;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] card_byte(host_state_t s);
    case (s.phase)
      PhReady: return ($urandom_range(0, 7) != 0) ? ByteIdle : 8'h00;
      PhPoll:  return ($urandom_range(0, 3) == 0) ? ByteIdle : card_response(s);
      PhR7: begin
        if (!clean && $urandom_range(0, 19) == 0) return 8'($urandom);
        case (s.bc)
          0, 1: return 8'h00;
          2: return 8'h01;
          default: return 8'hAA;
        endcase
      end
      PhOcr:   return (s.bc == 0) ? ($urandom_range(0, 1) ? 8'hC0 : 8'h80) : ByteIdle;
      PhToken: begin
        if ($urandom_range(0, 3) == 0) return ByteIdle;
        // a noisy card never starts a block, so only clean reads move data
        if (!clean) return 8'h05;
        if (s.left > 3 && $urandom_range(0, 1)) return 8'h05;
        return ByteToken;
      end
      PhData:  return 8'($urandom);
      default: return ($urandom_range(0, 4) == 0) ? 8'($urandom) : ByteIdle;
    endcase
  endfunction

  function automatic void add_word(item_t it);
    void'(host_step(gen_st, it));
    pending_words.push_back(it);
    n_sent++;
  endfunction

  // one host request, then card bytes and some ticks until it finishes
  task automatic run_request(logic [1:0] op, logic [31:0] sec, logic [15:0] cnt);
    item_t it;
    int    r, guard;
    it.op = op; it.sector = sec; it.count = cnt; it.miso = 8'($urandom);
    add_word(it);
    guard = 0;
    while (gen_st.phase != PhIdle && guard < 2000) begin
      it.op = OpByte; it.sector = $urandom; it.count = 16'($urandom);
      it.miso = card_byte(gen_st);
      r = $urandom_range(0, 99);
      if (r < 3) it.op = OpTick;
      else if (r < 4 && !clean) it.op = $urandom_range(0, 1) ? OpInit : OpRead;
      else if (r < 7 && !clean) it.miso = 8'($urandom);
      add_word(it);
      guard++;
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_timeouts(logic [15:0] init_to, logic [15:0] ready_to,
                                logic [15:0] token_to);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CfgInitTimeout; cfg_data_i <= init_to;
    @(posedge clk_i);
    cfg_idx_i <= CfgReadyTimeout; cfg_data_i <= ready_to;
    @(posedge clk_i);
    cfg_idx_i <= CfgTokenTimeout; cfg_data_i <= token_to;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_st.init_to = init_to; model_st.ready_to = ready_to; model_st.token_to = token_to;
    gen_st.init_to = init_to; gen_st.ready_to = ready_to; gen_st.token_to = token_to;
  endtask

  // short noisy requests until the word budget is used
  task automatic random_requests(int budget);
    int c;
    while (n_sent < budget) begin
      flavor = $urandom_range(0, 2);
      c = $urandom_range(0, 19);
      if (gen_st.uninit || c < 5) run_request(OpInit, $urandom, 16'($urandom));
      else if (c < 6) run_request(OpRead, $urandom, 16'd0);
      else if (c < 8) run_request(OpRead, $urandom, 16'($urandom));
      else run_request(OpRead, $urandom, 16'($urandom_range(1, 3)));
    end
  endtask

  // ---------------- mismatch reporting ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic check_word(result_t got, result_t want);
    if (got.mosi_byte !== want.mosi_byte) report_mismatch("mosi_byte", got.mosi_byte, want.mosi_byte);
    if (got.mosi_valid !== want.mosi_valid) report_mismatch("mosi_valid", got.mosi_valid, want.mosi_valid);
    if (got.cs_active !== want.cs_active) report_mismatch("cs_active", got.cs_active, want.cs_active);
    if (got.data_byte !== want.data_byte) report_mismatch("data_byte", got.data_byte, want.data_byte);
    if (got.data_valid !== want.data_valid) report_mismatch("data_valid", got.data_valid, want.data_valid);
    if (got.data_last !== want.data_last) report_mismatch("data_last", got.data_last, want.data_last);
    if (got.done !== want.done) report_mismatch("request_done", got.done, want.done);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.card_type !== want.card_type) report_mismatch("card_type", got.card_type, want.card_type);
    if (got.not_ready !== want.not_ready) report_mismatch("not_ready", got.not_ready, want.not_ready);
    if (got.fast_clock !== want.fast_clock) report_mismatch("fast_clock", got.fast_clock, want.fast_clock);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- driver ----------------
  int tx_gap = 0;
  bit tx_calm = 0;
  always @(posedge clk_i) begin
    item_t   it;
    result_t want;
    bit      nxt;
    if (rst_ni) begin
      if (push && !full) begin
        it = pending_words.pop_front();
        want = host_step(model_st, it);
        expected_words.push_back(want);
        if (!tx_calm) tx_gap = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
      nxt = 0;
      if (tx_gap > 0) tx_gap--;
      else if (pending_words.size() != 0) nxt = 1;
      push <= nxt;
      if (nxt) begin
        operation_i <= pending_words[0].op;
        sector_i    <= pending_words[0].sector;
        count_i     <= pending_words[0].count;
        miso_byte_i <= pending_words[0].miso;
      end
    end
  end

  // ---------------- monitor ----------------
  int rx_hold = 0;
  int rx_long = 0;
  bit rx_long_done = 0;
  bit rx_calm = 0;
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = {mosi_byte_o, mosi_valid_o, cs_active_o, data_byte_o, data_valid_o,
               data_last_o, request_done_o, status_o, card_type_o, not_ready_o, fast_clock_o};
        if (expected_words.size() == 0) report_mismatch("unexpected word", got, 0);
        else check_word(got, expected_words.pop_front());
        if (!rx_calm) rx_hold = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      // one long hold-off while a block read is queued, so the block fills and stalls
      if (!rx_long_done && pending_words.size() > 200) begin
        rx_long = 600;
        rx_long_done = 1;
      end
      if (rx_long > 0) begin
        rx_long--;
        pop <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    item_t it;
    model_st = host_reset();
    gen_st = host_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: requests before init, ignored byte, tick
    run_request(OpRead, 32'hFFFF_FFFF, 16'd5);
    run_request(OpRead, 32'h0, 16'd0);
    it.op = OpByte; it.sector = 32'hFFFF_FFFF; it.count = 16'hFFFF; it.miso = 8'h00;
    add_word(it);
    it.op = OpTick; it.miso = 8'hFF;
    add_word(it);

    // noisy requests under tight timeouts: busy, token and init timeouts
    write_timeouts(16'd3, 16'd1, 16'd1);
    random_requests(60);

    // clean SDv2 init, then one full block at a wrapping sector address
    write_timeouts(16'd1000, 16'd500, 16'd200);
    clean = 1;
    flavor = 0;
    run_request(OpInit, 32'h0, 16'h0);
    run_request(OpRead, 32'hFFFF_FFFF, 16'd1);
    clean = 0;

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_fifo.sv
hw/rtl/sdspi_engine.sv
hw/rtl/sd_card_spi_host.sv
tb/sv/testbench.sv
